// File: hdl/actr_pkg.sv
`default_nettype none
package actr_pkg;

    localparam int KeyWords = 4;
    localparam int RoundKeyDepth = 30;
    localparam int Rounds = 14;
    localparam int CfgIdxW = 3;

    localparam logic [CfgIdxW-1:0] CfgKey0 = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgKey1 = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgKey2 = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgKey3 = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgIvFront = 3'd4;
    localparam logic [CfgIdxW-1:0] CfgIvCounter = 3'd5;

    typedef struct packed {
        logic        start_req;
        logic [63:0] offset;
        logic [7:0]  data_byte;
        logic        last_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_out;
    } t_out_word;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] r;
        case (a)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // One AES round without AddRoundKey on a 128-bit state, byte 0 in the top bits; MixColumns only when mix is set.
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic mix);
        logic [7:0] t [16];
        logic [7:0] u [16];
        logic [7:0] a0, a1, a2, a3, al;
        logic [127:0] r;
        for (int j = 0; j < 16; j++) begin
            t[j] = sbox(s[127-8*j -: 8]);
        end
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) begin
                u[c*4+j] = t[((c+j)%4)*4+j];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = u[c*4]; a1 = u[c*4+1]; a2 = u[c*4+2]; a3 = u[c*4+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            if (mix) begin
                u[c*4]   = a0 ^ al ^ xtime(a0 ^ a1);
                u[c*4+1] = a1 ^ al ^ xtime(a1 ^ a2);
                u[c*4+2] = a2 ^ al ^ xtime(a2 ^ a3);
                u[c*4+3] = a3 ^ al ^ xtime(a3 ^ a0);
            end
        end
        for (int j = 0; j < 16; j++) begin
            r[127-8*j -: 8] = u[j];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hdl/aes256_ctr_keystream_xor.sv
`default_nettype none
// AES-256 counter-mode byte stream: each data word is one byte, XORed with the keystream
// byte at its stream position. The key schedule lives in a RAM of 30 64-bit entries and is
// rebuilt after reset and after each key write; no byte is taken meanwhile. A byte that
// needs a new keystream block runs the 15 rounds (two key-RAM reads per round, one read a
// cycle), writes the block into the keystream RAM byte by byte, then takes the keystream RAM
// read and the result register. Other bytes take the keystream RAM read, then the result
// register. Result back-pressure holds the output register; the next byte may start
// meanwhile but waits for that register before its result. A configuration write waits
// until the result register is empty.
module aes256_ctr_keystream_xor (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire actr_pkg::t_in_word        i_in_data,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output actr_pkg::t_out_word            o_out_data,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [actr_pkg::CfgIdxW-1:0] i_cfg_index,
    input  wire logic [63:0]               i_cfg_data
);
    import actr_pkg::*;

    localparam int KaW = $clog2(RoundKeyDepth);

    typedef enum logic [2:0] {
        S_EXPAND, S_IDLE, S_RDKEY, S_ROUND, S_KSWR, S_RDKS, S_OUT
    } t_state;

    t_state r_state;
    logic [63:0] r_key [KeyWords];
    logic [63:0] r_iv_front, r_iv_ctr, r_ctr;
    logic [3:0]  r_bidx;
    logic        r_ready_blk;
    logic [31:0] r_w [8];      // sliding window of the last eight schedule words
    logic [5:0]  r_wi;         // schedule word number being made
    logic [7:0]  r_rcon;
    logic [127:0] r_s;
    logic [3:0]  r_round;
    logic        r_half;
    logic [KaW-1:0] r_ka;
    logic [63:0] r_khi;
    logic [3:0]  r_ksi;
    logic [7:0]  r_data;
    logic        r_last;
    logic        r_ovalid;
    t_out_word   r_odata;

    // Key RAM
    logic            k_we;
    logic [KaW-1:0]  k_wa, k_ra;
    logic [63:0]     k_wd, k_rd;
    // Keystream RAM
    logic            s_we;
    logic [3:0]      s_wa, s_ra;
    logic [7:0]      s_wd, s_rd;

    actr_ram #(.Width(64), .Depth(RoundKeyDepth)) u_kram (
        .i_clk(i_clk), .i_we(k_we), .i_waddr(k_wa), .i_wdata(k_wd),
        .i_raddr(k_ra), .o_rdata(k_rd)
    );
    actr_ram #(.Width(8), .Depth(16)) u_sram (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_wa), .i_wdata(s_wd),
        .i_raddr(s_ra), .o_rdata(s_rd)
    );

    // Next schedule word from the window.
    logic [31:0] n_word, t_prev;
    always_comb begin
        t_prev = r_w[7];
        if (r_wi[2:0] == 3'd0) begin
            n_word = r_w[0] ^ sub_word({t_prev[23:0], t_prev[31:24]}) ^ {r_rcon, 24'h0};
        end else if (r_wi[2:0] == 3'd4) begin
            n_word = r_w[0] ^ sub_word(t_prev);
        end else begin
            n_word = r_w[0] ^ t_prev;
        end
    end

    logic [63:0] ctr_sum;
    logic [127:0] blk_in;
    always_comb begin
        ctr_sum = r_iv_ctr + r_ctr;
        blk_in[127:64] = r_iv_front;
        for (int j = 0; j < 8; j++) begin
            blk_in[63-8*j -: 8] = ctr_sum[8*j +: 8];
        end
    end

    logic in_acc, out_free;
    assign out_free = !r_ovalid || i_out_ready;
    assign in_acc = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE) && !(i_cfg_valid && o_cfg_ready);
    assign o_cfg_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_out_valid = r_ovalid;
    assign o_out_data = r_odata;

    // Key RAM write during expansion: two words make one RAM entry.
    always_comb begin
        k_we = (r_state == S_EXPAND) && r_wi[0] && r_wi >= 6'd9;
        k_wa = KaW'((r_wi - 6'd8) >> 1) + KaW'(4);
        k_wd = {r_w[7], n_word};
        if (r_state == S_EXPAND && r_wi < 6'd8) begin
            k_we = r_wi[0];
            k_wa = KaW'(r_wi >> 1);
            k_wd = {r_w[7], r_key[r_wi[2:1]][31:0]};
        end
        k_ra = r_ka;
        s_we = (r_state == S_KSWR);
        s_wa = r_ksi;
        s_wd = r_s[127-8*r_ksi -: 8];
        s_ra = r_bidx;
    end

    logic [127:0] rkey;
    assign rkey = {r_khi, k_rd};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_EXPAND;
            for (int i = 0; i < KeyWords; i++) r_key[i] <= '0;
            r_iv_front <= '0;
            r_iv_ctr <= '0;
            r_ctr <= '0;
            r_bidx <= '0;
            r_ready_blk <= 1'b0;
            r_wi <= '0;
            r_rcon <= 8'h01;
            r_ovalid <= 1'b0;
            r_round <= '0;
            r_half <= 1'b0;
            r_ka <= '0;
            r_ksi <= '0;
            for (int i = 0; i < 8; i++) r_w[i] <= '0;
        end else begin
            if (r_ovalid && i_out_ready && r_state != S_OUT) r_ovalid <= 1'b0;
            case (r_state)
                S_EXPAND: begin
                    // Words 0..7 load the key; the RAM entry is written from the pair.
                    if (r_wi < 6'd8) begin
                        for (int i = 0; i < 7; i++) r_w[i] <= r_w[i+1];
                        r_w[7] <= r_wi[0] ? r_key[r_wi[2:1]][31:0]
                                          : r_key[r_wi[2:1]][63:32];
                    end else begin
                        for (int i = 0; i < 7; i++) r_w[i] <= r_w[i+1];
                        r_w[7] <= n_word;
                        if (r_wi[2:0] == 3'd0) r_rcon <= xtime(r_rcon);
                    end
                    if (r_wi == 6'd59) begin
                        r_state <= S_IDLE;
                        r_wi <= '0;
                        r_rcon <= 8'h01;
                    end else begin
                        r_wi <= r_wi + 6'd1;
                    end
                end
                S_IDLE: begin
                    if (i_cfg_valid && o_cfg_ready) begin
                        case (i_cfg_index)
                            CfgKey0, CfgKey1, CfgKey2, CfgKey3: begin
                                r_key[i_cfg_index[1:0]] <= i_cfg_data;
                                r_ready_blk <= 1'b0;
                                r_state <= S_EXPAND;
                                for (int i = 0; i < 8; i++) r_w[i] <= '0;
                            end
                            CfgIvFront: begin
                                r_iv_front <= i_cfg_data;
                                r_ready_blk <= 1'b0;
                            end
                            CfgIvCounter: begin
                                r_iv_ctr <= i_cfg_data;
                                r_ready_blk <= 1'b0;
                            end
                            default: ;
                        endcase
                    end else if (in_acc) begin
                        r_data <= i_in_data.data_byte;
                        r_last <= i_in_data.last_byte;
                        if (i_in_data.start_req) begin
                            r_ctr <= i_in_data.offset >> 4;
                            r_bidx <= i_in_data.offset[3:0];
                        end
                        if (i_in_data.start_req || !r_ready_blk) begin
                            r_round <= '0;
                            r_half <= 1'b0;
                            r_ka <= '0;
                            r_state <= S_RDKEY;
                        end else begin
                            r_state <= S_RDKS;
                        end
                    end
                end
                S_RDKEY: begin
                    // The first key-RAM read is issued; one read follows every cycle.
                    r_half <= 1'b1;
                    r_ka <= KaW'(1);
                    r_state <= S_ROUND;
                    if (r_round == 4'd0) r_s <= blk_in;
                end
                S_ROUND: begin
                    if (r_ka != KaW'(RoundKeyDepth - 1)) r_ka <= r_ka + KaW'(1);
                    if (r_half) begin
                        // Upper half of this round's key is on the RAM output.
                        r_khi <= k_rd;
                        r_half <= 1'b0;
                    end else begin
                        if (r_round == 4'd0) begin
                            r_s <= r_s ^ rkey;
                        end else begin
                            r_s <= aes_round(r_s, r_round != 4'(Rounds)) ^ rkey;
                        end
                        r_half <= 1'b1;
                        if (r_round == 4'(Rounds)) begin
                            r_state <= S_KSWR;
                            r_ksi <= '0;
                        end else begin
                            r_round <= r_round + 4'd1;
                        end
                    end
                end
                S_KSWR: begin
                    r_ksi <= r_ksi + 4'd1;
                    if (r_ksi == 4'd15) begin
                        r_ready_blk <= 1'b1;
                        r_state <= S_RDKS;
                    end
                end
                S_RDKS: begin
                    r_state <= S_OUT;
                end
                default: begin
                    // S_OUT: keystream byte is on the RAM output.
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_odata.out_byte <= r_data ^ s_rd;
                        r_odata.last_out <= r_last;
                        r_bidx <= r_bidx + 4'd1;
                        if (r_bidx == 4'd15) begin
                            r_ctr <= r_ctr + 64'd1;
                            r_ready_blk <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// File: hdl/actr_ram.sv
`default_nettype none
module actr_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire
